>>> design/pbosc_pkg.sv
package pbosc_pkg;

  // Request kinds carried on the input tuser
  localparam logic [1:0] REQ_TICK = 2'd0;
  localparam logic [1:0] REQ_TRIG = 2'd1;
  localparam logic [1:0] REQ_STOP = 2'd2;

  // Waveform codes
  localparam logic [2:0] WAVE_SINE   = 3'd0;
  localparam logic [2:0] WAVE_SAW    = 3'd1;
  localparam logic [2:0] WAVE_SQUARE = 3'd2;
  localparam logic [2:0] WAVE_PULSE  = 3'd3;
  localparam logic [2:0] WAVE_NOISE  = 3'd4;
  localparam logic [2:0] WAVE_SH     = 3'd5;
  localparam logic [2:0] WAVE_TRI    = 3'd6;

  // Configuration register indexes
  localparam logic [2:0] REG_WAVEFORM    = 3'd0;
  localparam logic [2:0] REG_PHASE_STEP  = 3'd1;
  localparam logic [2:0] REG_VOLUME      = 3'd2;
  localparam logic [2:0] REG_PULSE_WIDTH = 3'd3;
  localparam logic [2:0] REG_LFO_MODE    = 3'd4;
  localparam logic [2:0] REG_SYNC        = 3'd5;
  localparam logic [2:0] REG_START_PHASE = 3'd6;
  localparam logic [2:0] REG_HOLD_PERIOD = 3'd7;

  // Quotient bits of the polyBLEP ratio
  localparam int DIV_STEPS = 15;

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_SIN1, S_SIN2, S_SIN3, S_SIN4, S_SINF,
    S_BSET, S_BDIV, S_BSQ, S_BACC, S_SCALE, S_INC, S_ADV, S_PUSH
  } state_t;

  typedef struct packed {
    logic latch_in;
    logic dec;
    logic zero_y;
    logic sin1;
    logic sin2;
    logic sin3;
    logic sin4;
    logic sinf;
    logic bset;
    logic bdiv;
    logic bsq;
    logic bacc;
    logic bnext;
    logic scale;
    logic inc;
    logic adv;
    logic push;
  } cmd_t;

  typedef struct packed {
    logic [1:0] req;
    logic [2:0] wave;
    logic       active;
    logic       blep_zero;
    logic       blep_sel;
    logic       div_last;
    logic       out_free;
  } sts_t;

endpackage

>>> design/pbosc_ctrl.sv
module pbosc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  pbosc_pkg::sts_t  sts,
  output pbosc_pkg::cmd_t  cmd
);

  pbosc_pkg::state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pbosc_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      pbosc_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = pbosc_pkg::S_DEC;
        end
      end
      pbosc_pkg::S_DEC: begin
        cmd.dec = 1'b1;
        if (sts.req != pbosc_pkg::REQ_TICK) begin
          state_nxt = pbosc_pkg::S_IDLE;
        end else if (!sts.active) begin
          cmd.zero_y = 1'b1;
          state_nxt  = pbosc_pkg::S_PUSH;
        end else begin
          case (sts.wave)
            pbosc_pkg::WAVE_SINE: state_nxt = pbosc_pkg::S_SIN1;
            pbosc_pkg::WAVE_SAW, pbosc_pkg::WAVE_SQUARE, pbosc_pkg::WAVE_PULSE:
              state_nxt = pbosc_pkg::S_BSET;
            default: state_nxt = pbosc_pkg::S_SCALE;
          endcase
        end
      end
      pbosc_pkg::S_SIN1: begin
        cmd.sin1  = 1'b1;
        state_nxt = pbosc_pkg::S_SIN2;
      end
      pbosc_pkg::S_SIN2: begin
        cmd.sin2  = 1'b1;
        state_nxt = pbosc_pkg::S_SIN3;
      end
      pbosc_pkg::S_SIN3: begin
        cmd.sin3  = 1'b1;
        state_nxt = pbosc_pkg::S_SIN4;
      end
      pbosc_pkg::S_SIN4: begin
        cmd.sin4  = 1'b1;
        state_nxt = pbosc_pkg::S_SINF;
      end
      pbosc_pkg::S_SINF: begin
        cmd.sinf  = 1'b1;
        state_nxt = pbosc_pkg::S_SCALE;
      end
      pbosc_pkg::S_BSET: begin
        cmd.bset = 1'b1;
        if (!sts.blep_zero) begin
          state_nxt = pbosc_pkg::S_BDIV;
        end else if (sts.wave == pbosc_pkg::WAVE_SQUARE && !sts.blep_sel) begin
          cmd.bnext = 1'b1;
          state_nxt = pbosc_pkg::S_BSET;
        end else begin
          state_nxt = pbosc_pkg::S_SCALE;
        end
      end
      pbosc_pkg::S_BDIV: begin
        cmd.bdiv = 1'b1;
        if (sts.div_last) begin
          state_nxt = pbosc_pkg::S_BSQ;
        end
      end
      pbosc_pkg::S_BSQ: begin
        cmd.bsq   = 1'b1;
        state_nxt = pbosc_pkg::S_BACC;
      end
      pbosc_pkg::S_BACC: begin
        cmd.bacc = 1'b1;
        if (sts.wave == pbosc_pkg::WAVE_SQUARE && !sts.blep_sel) begin
          cmd.bnext = 1'b1;
          state_nxt = pbosc_pkg::S_BSET;
        end else begin
          state_nxt = pbosc_pkg::S_SCALE;
        end
      end
      pbosc_pkg::S_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = pbosc_pkg::S_INC;
      end
      pbosc_pkg::S_INC: begin
        cmd.inc   = 1'b1;
        state_nxt = pbosc_pkg::S_ADV;
      end
      pbosc_pkg::S_ADV: begin
        cmd.adv   = 1'b1;
        state_nxt = pbosc_pkg::S_PUSH;
      end
      pbosc_pkg::S_PUSH: begin
        if (sts.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = pbosc_pkg::S_IDLE;
        end
      end
      default: state_nxt = pbosc_pkg::S_IDLE;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_dec_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pbosc_pkg::S_DEC) |-> $past(state_r == pbosc_pkg::S_IDLE))
    else $error("decode entered from a state other than idle");
  a_div_complete: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pbosc_pkg::S_BSQ) |-> $past(state_r == pbosc_pkg::S_BDIV) && $past(sts.div_last))
    else $error("blep square started before the divide finished");
  a_push_returns: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pbosc_pkg::S_PUSH && sts.out_free) |=> (state_r == pbosc_pkg::S_IDLE))
    else $error("push did not return to idle");
`endif

endmodule

>>> design/pbosc_dp.sv
module pbosc_dp #(
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int PHASE_BITS       = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [2:0]             cfg_index,
  input  logic [31:0]            cfg_data,
  input  logic [1:0]             in_tuser,
  input  logic [47:0]            in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [15:0]            out_tdata,
  input  pbosc_pkg::cmd_t        cmd,
  output pbosc_pkg::sts_t        sts
);

  localparam int          SIN_K    = $clog2(SINE_TABLE_DEPTH + 1) - 1;
  localparam logic [31:0] SIN_MASK = 32'hFFFF_FFFF << (32 - SIN_K);
  localparam logic [31:0] PH_MASK  = 32'hFFFF_FFFF << (32 - PHASE_BITS);

  // Configuration
  logic [2:0]  waveform_r;
  logic [31:0] step_r, pw_r, start_r;
  logic [15:0] volume_r, hold_period_r;
  logic        lfo_r, sync_r;

  // Oscillator state
  logic [31:0]        phase_r, noise_a_r, noise_c_r;
  logic               active_r;
  logic signed [16:0] hold_cnt_r;
  logic signed [15:0] held_r;

  // Latched item
  logic [1:0]         req_r;
  logic signed [15:0] pm_r;
  logic [31:0]        pwm_r;

  // Work registers
  logic signed [17:0] acc_r;
  logic signed [50:0] prod_r;
  logic [15:0]        z2_r;
  logic [31:0]        rem_r;
  logic [14:0]        q_r;
  logic [3:0]         cnt_r;
  logic               bneg_r, bsel_r;
  logic signed [15:0] y_r;
  logic               out_valid_r;
  logic [15:0]        out_data_r;

  // Shared multiplier operands
  logic signed [32:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [50:0] p15;

  // Sine helpers
  logic [31:0] sq;
  logic [16:0] zr, z;
  logic [15:0] inner, mid;
  logic [16:0] vc;

  // Blep helpers
  logic [31:0] bt, bn;
  logic [32:0] brest, rem2;
  logic        bless, binrest, bzero, bge;
  logic [15:0] bd;
  logic signed [17:0] bc;

  // Decode helpers
  logic [31:0]        na, nc, ps;
  logic signed [15:0] nv;
  logic signed [16:0] tr;
  logic signed [17:0] acc_dec;

  // Output scaling
  logic signed [50:0] ysh;
  logic [31:0]        inc;

  assign p15 = prod_r >>> 15;

  // Sine argument: quarter-wave fold of the cut phase
  always_comb begin
    sq = phase_r & SIN_MASK;
    zr = {2'b00, sq[29:15]};
    z  = sq[30] ? (17'd32768 - zr) : zr;
    inner = 16'd21024 - p15[15:0];
    mid   = 16'd51472 - p15[15:0];
    vc    = (p15[16:0] > 17'd32768) ? 17'd32768 : p15[16:0];
  end

  // Blep region select and divide step
  always_comb begin
    bt      = bsel_r ? (phase_r + 32'h8000_0000) : phase_r;
    bless   = bt < step_r;
    brest   = 33'h1_0000_0000 - {1'b0, bt};
    binrest = brest < {1'b0, step_r};
    bzero   = (step_r == 32'd0) || (!bless && !binrest);
    bn      = bless ? bt : brest[31:0];
    rem2    = {rem_r, 1'b0};
    bge     = rem2 >= {1'b0, step_r};
    bd      = 16'(17'd32768 - {2'b00, q_r});
    bc      = bneg_r ? -$signed({1'b0, p15[16:0]}) : $signed({1'b0, p15[16:0]});
  end

  // Tick decode values
  always_comb begin
    na = noise_a_r ^ noise_c_r;
    nc = noise_c_r + na;
    nv = $signed(noise_c_r[31:16]);
    ps = phase_r + pw_r + pwm_r;
    tr = $signed({1'b0, phase_r[31:16]}) - 17'sd32768;
    if (tr < 0) begin
      tr = -tr;
    end
    case (waveform_r)
      pbosc_pkg::WAVE_SAW:
        acc_dec = $signed({2'b00, phase_r[31:16]}) - 18'sd32768;
      pbosc_pkg::WAVE_SQUARE:
        acc_dec = phase_r[31] ? -18'sd32768 : 18'sd32768;
      pbosc_pkg::WAVE_PULSE:
        acc_dec = $signed({2'b00, phase_r[31:16]}) - $signed({2'b00, ps[31:16]});
      pbosc_pkg::WAVE_NOISE:
        acc_dec = 18'(nv);
      pbosc_pkg::WAVE_SH:
        acc_dec = hold_cnt_r[16] ? 18'(nv) : 18'(held_r);
      pbosc_pkg::WAVE_TRI:
        acc_dec = ($signed({tr[16], tr}) <<< 1) - 18'sd32768;
      default: acc_dec = '0;
    endcase
  end

  // Select multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd.sin1 || cmd.sin4) begin
      mul_a = $signed({16'd0, z});
      mul_b = cmd.sin1 ? $signed({1'b0, z}) : $signed({2'b00, mid});
    end else if (cmd.sin2) begin
      mul_a = $signed({17'd0, p15[15:0]});
      mul_b = 18'sd2320;
    end else if (cmd.sin3) begin
      mul_a = $signed({17'd0, z2_r});
      mul_b = $signed({2'b00, inner});
    end else if (cmd.bsq) begin
      mul_a = $signed({17'd0, bd});
      mul_b = $signed({2'b00, bd});
    end else if (cmd.scale) begin
      mul_a = 33'(acc_r);
      mul_b = $signed({2'b00, volume_r});
    end else if (cmd.inc) begin
      mul_a = $signed({1'b0, step_r});
      mul_b = 18'sd32768 + 18'(pm_r);
    end
  end

  // Round and scale the product; pick the phase increment
  always_comb begin
    ysh = (prod_r + 51'sd16384) >>> 15;
    inc = lfo_r ? prod_r[46:15] : step_r;
  end

  // Multiplier and work registers
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (cmd.latch_in) begin
      req_r <= in_tuser;
      pm_r  <= $signed(in_tdata[15:0]);
      pwm_r <= in_tdata[47:16];
    end
    if (cmd.dec) begin
      acc_r <= acc_dec;
    end
    if (cmd.sin2) begin
      z2_r <= p15[15:0];
    end
    if (cmd.sinf) begin
      acc_r <= sq[31] ? -$signed({1'b0, vc}) : $signed({1'b0, vc});
    end
    if (cmd.bset) begin
      rem_r  <= bn;
      q_r    <= '0;
      cnt_r  <= 4'(pbosc_pkg::DIV_STEPS);
      bneg_r <= bless;
    end
    if (cmd.bdiv) begin
      rem_r <= bge ? 32'(rem2 - {1'b0, step_r}) : rem2[31:0];
      q_r   <= {q_r[13:0], bge};
      cnt_r <= cnt_r - 4'd1;
    end
    if (cmd.bacc) begin
      acc_r <= (waveform_r == pbosc_pkg::WAVE_SQUARE && !bsel_r) ? acc_r + bc : acc_r - bc;
    end
    if (cmd.zero_y) begin
      y_r <= '0;
    end
    if (cmd.inc) begin
      if (ysh > 51'sd32767) begin
        y_r <= 16'sh7FFF;
      end else if (ysh < -51'sd32768) begin
        y_r <= -16'sh8000;
      end else begin
        y_r <= ysh[15:0];
      end
    end
    if (cmd.push) begin
      out_data_r <= y_r;
    end
  end

  // Configuration, oscillator state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      waveform_r    <= pbosc_pkg::WAVE_SINE;
      step_r        <= 32'd42852281;
      volume_r      <= 16'd32768;
      pw_r          <= 32'h8000_0000;
      lfo_r         <= 1'b0;
      sync_r        <= 1'b1;
      start_r       <= '0;
      hold_period_r <= 16'd1;
      phase_r       <= '0;
      active_r      <= 1'b0;
      noise_a_r     <= 32'h6745_2301;
      noise_c_r     <= 32'hefcd_ab89;
      hold_cnt_r    <= '0;
      held_r        <= '0;
      bsel_r        <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          pbosc_pkg::REG_WAVEFORM: begin
            waveform_r <= cfg_data[2:0];
            held_r     <= '0;
          end
          pbosc_pkg::REG_PHASE_STEP:  step_r        <= cfg_data;
          pbosc_pkg::REG_VOLUME:      volume_r      <= cfg_data[15:0];
          pbosc_pkg::REG_PULSE_WIDTH: pw_r          <= cfg_data;
          pbosc_pkg::REG_LFO_MODE:    lfo_r         <= cfg_data[0];
          pbosc_pkg::REG_SYNC:        sync_r        <= cfg_data[0];
          pbosc_pkg::REG_START_PHASE: start_r       <= cfg_data;
          pbosc_pkg::REG_HOLD_PERIOD: hold_period_r <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (cmd.dec) begin
        bsel_r <= 1'b0;
        case (req_r)
          pbosc_pkg::REQ_TRIG: begin
            if (sync_r) begin
              phase_r <= start_r & PH_MASK;
            end
            active_r <= 1'b1;
          end
          pbosc_pkg::REQ_STOP: active_r <= 1'b0;
          pbosc_pkg::REQ_TICK: begin
            // Step noise (noise or sample-and-hold) and the hold counter (sample-and-hold) on an active tick
            if (active_r && (waveform_r == pbosc_pkg::WAVE_NOISE ||
                             waveform_r == pbosc_pkg::WAVE_SH)) begin
              noise_a_r <= na;
              noise_c_r <= nc;
            end
            if (active_r && waveform_r == pbosc_pkg::WAVE_SH) begin
              if (hold_cnt_r[16]) begin
                held_r     <= nv;
                hold_cnt_r <= $signed({1'b0, hold_period_r}) - 17'sd1;
              end else begin
                hold_cnt_r <= hold_cnt_r - 17'sd1;
              end
            end
          end
          default: ;
        endcase
      end
      if (cmd.bnext) begin
        bsel_r <= 1'b1;
      end
      if (cmd.adv) begin
        phase_r <= (phase_r + inc) & PH_MASK;
      end
      if (cmd.push) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Status to the controller
  always_comb begin
    sts.req       = req_r;
    sts.wave      = waveform_r;
    sts.active    = active_r;
    sts.blep_zero = bzero;
    sts.blep_sel  = bsel_r;
    sts.div_last  = (cnt_r == 4'd1);
    sts.out_free  = !out_valid_r || out_tready;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

>>> design/polyblep_multiwave_oscillator_unit.sv
// From acceptance to result valid: an inactive tick is decoded and pushed as zero;
// noise, sample-and-hold, triangle or an unknown waveform pass decode, scale,
// increment, advance and push; sine adds SIN1 to SIN4 and SINF; saw and pulse add
// a polyBLEP divide near an edge, square one per edge; trigger and stop hold off the
// input while decoded. Throughput: one item at a time, the next accepted in the cycle
// after the push; polyBLEP divide loops set the rate, a held-off output stalls it.
// Reset (rst_n, synchronous, active low) loads register defaults, clears phase
// and the active flag, and seeds the noise generator.
module polyblep_multiwave_oscillator_unit #(
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int PHASE_BITS       = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [15:0] pitch_mod, [47:16] pw_mod
  input  logic [1:0]  in_tuser,   // [1:0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [15:0] sample
);

  pbosc_pkg::cmd_t cmd;
  pbosc_pkg::sts_t sts;

  pbosc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pbosc_dp #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
    .PHASE_BITS       (PHASE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

>>> sim/tb_polyblep_multiwave_oscillator_unit.sv
`timescale 1ns / 1ps

module tb_polyblep_multiwave_oscillator_unit;

  localparam logic [1:0] REQ_RESERVED = 2'd3;
  localparam int         SINE_BITS    = 10;   // log2 of the sine depth
  localparam int         SETTLE       = 60;   // beyond the longest tick latency

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;   // [15:0] pitch_mod, [47:16] pw_mod
  logic [1:0]  in_tuser = '0;   // [1:0] req_type
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // [15:0] sample

  polyblep_multiwave_oscillator_unit uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Oscillator state mirrored by the predictor
  logic [2:0]  osc_wave;
  logic [31:0] osc_step, osc_pw, osc_start, osc_phase, osc_na, osc_nc;
  logic [15:0] osc_vol, osc_hold_period;
  logic        osc_lfo, osc_sync, osc_active;
  int          osc_hold_count, osc_held;

  logic [15:0] pending_samples[$];
  int          mismatches = 0;
  int          hold_request = 0;
  bit          no_gaps = 1'b0;

  function automatic int sine_value(logic [31:0] ph);
    logic [31:0]     q;
    longint unsigned z, z2, inner, mid;
    int              v;
    q = ph & (32'hFFFF_FFFF << (32 - SINE_BITS));
    z = 64'((q >> 15) & 32'h7FFF);
    if (q[30]) z = 32768 - z;
    z2 = (z * z) >> 15;
    inner = 21024 - ((z2 * 2320) >> 15);
    mid = 51472 - ((z2 * inner) >> 15);
    v = int'((z * mid) >> 15);
    if (v > 32768) v = 32768;
    return q[31] ? -v : v;
  endfunction

  function automatic int blep_value(logic [31:0] t, logic [31:0] dt);
    longint unsigned u, rest;
    if (dt == 0) return 0;
    if (t < dt) begin
      u = 32768 - (({32'd0, t} << 15) / dt);
      return -int'((u * u) >> 15);
    end
    rest = 64'h1_0000_0000 - t;
    if (rest < dt) begin
      u = 32768 - ((rest << 15) / dt);
      return int'((u * u) >> 15);
    end
    return 0;
  endfunction

  function automatic int noise_next();
    int v;
    osc_na = osc_na ^ osc_nc;
    v = int'($signed(osc_nc[31:16]));
    osc_nc = osc_nc + osc_na;
    return v;
  endfunction

  function automatic int saw_value();
    return int'(osc_phase >> 16) - 32768 - blep_value(osc_phase, osc_step);
  endfunction

  // Advance the oscillator by one item; report whether it yields a sample
  function automatic bit predict_sample(logic [1:0] req, logic [15:0] pm, logic [31:0] pwm,
                                        output logic [15:0] smp);
    int              w, n, r;
    logic [31:0]     inc, s;
    longint          p, y;
    longint unsigned q;
    smp = '0;
    case (req)
      pbosc_pkg::REQ_TRIG: begin
        if (osc_sync) osc_phase = osc_start;
        osc_active = 1'b1;
        return 1'b0;
      end
      pbosc_pkg::REQ_STOP: begin
        osc_active = 1'b0;
        return 1'b0;
      end
      pbosc_pkg::REQ_TICK: ;
      default: return 1'b0;
    endcase
    if (!osc_active) return 1'b1;
    case (osc_wave)
      pbosc_pkg::WAVE_SINE:   w = sine_value(osc_phase);
      pbosc_pkg::WAVE_SAW:    w = saw_value();
      pbosc_pkg::WAVE_SQUARE: begin
        w = osc_phase[31] ? -32768 : 32768;
        w += blep_value(osc_phase, osc_step);
        w -= blep_value(osc_phase + 32'h8000_0000, osc_step);
      end
      pbosc_pkg::WAVE_PULSE: begin
        s = osc_phase + osc_pw + pwm;
        w = saw_value() + 32768 - int'(s >> 16);
      end
      pbosc_pkg::WAVE_NOISE:  w = noise_next();
      pbosc_pkg::WAVE_SH: begin
        n = noise_next();
        if (osc_hold_count < 0) begin
          osc_held = n;
          osc_hold_count = int'(osc_hold_period);
        end
        w = osc_held;
        osc_hold_count--;
      end
      pbosc_pkg::WAVE_TRI: begin
        r = int'(osc_phase >> 16) - 32768;
        if (r < 0) r = -r;
        w = 2 * r - 32768;
      end
      default: w = 0;
    endcase
    inc = osc_step;
    if (osc_lfo) inc = 32'((64'(osc_step) * 64'(32768 + int'($signed(pm)))) >> 15);
    osc_phase = osc_phase + inc;
    p = longint'(w) * longint'(osc_vol);
    q = (64'(p + (64'd1 << 40)) + 16384) >> 15;
    y = longint'(q) - (64'sd1 <<< 25);
    if (y > 32767) y = 32767;
    if (y < -32768) y = -32768;
    smp = y[15:0];
    return 1'b1;
  endfunction

  function automatic int gap_len();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Write one register; the enable stays high until write_done
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      pbosc_pkg::REG_WAVEFORM:    begin osc_wave = val[2:0]; osc_held = 0; end
      pbosc_pkg::REG_PHASE_STEP:  osc_step = val;
      pbosc_pkg::REG_VOLUME:      osc_vol = val[15:0];
      pbosc_pkg::REG_PULSE_WIDTH: osc_pw = val;
      pbosc_pkg::REG_LFO_MODE:    osc_lfo = val[0];
      pbosc_pkg::REG_SYNC:        osc_sync = val[0];
      pbosc_pkg::REG_START_PHASE: osc_start = val;
      pbosc_pkg::REG_HOLD_PERIOD: osc_hold_period = val[15:0];
      default: ;
    endcase
  endtask

  task automatic write_done();
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one item, wait for its acceptance, then idle a random while
  task automatic send_item(logic [1:0] req, logic [15:0] pm, logic [31:0] pwm);
    logic [15:0] smp;
    int          g;
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {pwm, pm};
    do @(posedge clk); while (!in_tready);
    if (predict_sample(req, pm, pwm, smp)) pending_samples.push_back(smp);
    g = gap_len();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Drop valid and wait until every sample is back and the block is idle
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic tick(logic [15:0] pm = 16'h0000, logic [31:0] pwm = 32'h0);
    send_item(pbosc_pkg::REQ_TICK, pm, pwm);
  endtask

  task automatic test_reset_state();
    tick(16'h8000, 32'hFFFF_FFFF);
    send_item(REQ_RESERVED, 16'h7FFF, 32'hFFFF_FFFF);
    send_item(pbosc_pkg::REQ_TRIG, 16'h0, 32'h0);
    tick(); tick(16'h7FFF);
    send_item(pbosc_pkg::REQ_STOP, 16'h0, 32'h0);
    tick();
    drain();
  endtask

  task automatic test_each_waveform();
    for (int wv = 0; wv < 8; wv++) begin
      write_reg(pbosc_pkg::REG_WAVEFORM, 32'(wv));
      write_reg(pbosc_pkg::REG_PHASE_STEP, (wv == 2) ? 32'h4000_0000 : 32'h1000_0000);
      write_done();
      send_item(pbosc_pkg::REQ_TRIG, 16'h0, 32'h0);
      tick(16'h8000, 32'h0);
      tick(16'h7FFF, 32'hFFFF_FFFF);
      drain();
    end
  endtask

  task automatic test_corner_settings();
    // zero step, wide step, full-scale step, silent and unity volume
    write_reg(pbosc_pkg::REG_WAVEFORM, 32'(pbosc_pkg::WAVE_SQUARE));
    write_reg(pbosc_pkg::REG_PHASE_STEP, 32'h0);
    write_reg(pbosc_pkg::REG_VOLUME, 32'd0);
    write_done();
    send_item(pbosc_pkg::REQ_TRIG, 16'h0, 32'h0);
    tick();
    drain();
    write_reg(pbosc_pkg::REG_VOLUME, 32'd32768);
    write_reg(pbosc_pkg::REG_PHASE_STEP, 32'hFFFF_FFFF);
    write_reg(pbosc_pkg::REG_LFO_MODE, 32'd1);
    write_reg(pbosc_pkg::REG_SYNC, 32'd0);
    write_reg(pbosc_pkg::REG_START_PHASE, 32'hFFFF_FFFF);
    write_done();
    tick(16'h7FFF); tick(16'h8000);
    drain();
    write_reg(pbosc_pkg::REG_PHASE_STEP, 32'h8000_0000);
    write_reg(pbosc_pkg::REG_SYNC, 32'd1);
    write_reg(pbosc_pkg::REG_WAVEFORM, 32'(pbosc_pkg::WAVE_SH));
    write_reg(pbosc_pkg::REG_HOLD_PERIOD, 32'd0);
    write_reg(pbosc_pkg::REG_PULSE_WIDTH, 32'hFFFF_FFFF);
    write_done();
    send_item(pbosc_pkg::REQ_TRIG, 16'h0, 32'h0);
    tick(); tick(16'h7FFF);
    drain();
  endtask

  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 7))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return $urandom;
      default: return $urandom_range(0, 32'h0800_0000);
    endcase
  endfunction

  task automatic randomize_registers();
    write_reg(pbosc_pkg::REG_WAVEFORM, $urandom_range(0, 7));
    write_reg(pbosc_pkg::REG_PHASE_STEP, pick32());
    write_reg(pbosc_pkg::REG_VOLUME,
              ($urandom_range(0, 3) == 0) ? 32'd32768 : $urandom_range(0, 32768));
    write_reg(pbosc_pkg::REG_PULSE_WIDTH, pick32());
    write_reg(pbosc_pkg::REG_LFO_MODE, $urandom_range(0, 1));
    write_reg(pbosc_pkg::REG_SYNC, $urandom_range(0, 1));
    write_reg(pbosc_pkg::REG_START_PHASE, pick32());
    write_reg(pbosc_pkg::REG_HOLD_PERIOD,
              ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 6));
    write_done();
  endtask

  task automatic test_random_phases();
    int r;
    for (int ph = 0; ph < 14; ph++) begin
      randomize_registers();
      no_gaps = (ph % 5 == 4);
      send_item(pbosc_pkg::REQ_TRIG, 16'($urandom), $urandom);
      for (int i = 0; i < 55; i++) begin
        r = $urandom_range(0, 99);
        if (r < 88) tick(16'($urandom), $urandom);
        else if (r < 93) send_item(pbosc_pkg::REQ_TRIG, 16'($urandom), $urandom);
        else if (r < 97) send_item(pbosc_pkg::REQ_STOP, 16'($urandom), $urandom);
        else send_item(REQ_RESERVED, 16'($urandom), $urandom);
      end
      no_gaps = 1'b0;
      drain();
    end
  endtask

  task automatic test_output_stall();
    write_reg(pbosc_pkg::REG_WAVEFORM, 32'(pbosc_pkg::WAVE_TRI));
    write_done();
    send_item(pbosc_pkg::REQ_TRIG, 16'h0, 32'h0);
    hold_request = 400;
    for (int i = 0; i < 20; i++) tick(16'($urandom), $urandom);
    drain();
  endtask

  // Receiver: random ready with short and occasional long holds; check samples
  initial begin
    int hold_left;
    int r;
    logic [15:0] want;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        if (pending_samples.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected sample %h", out_tdata);
        end else begin
          want = pending_samples.pop_front();
          if (out_tdata !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("sample mismatch: expected %h, got %h", want, out_tdata);
          end
        end
      end
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r >= 97) hold_left = $urandom_range(10, 40);
        out_tready <= (r < 75);
      end
    end
  end

  initial begin
    #20ms;
    $display("tb_polyblep_multiwave_oscillator_unit: FAIL");
    $finish;
  end

  initial begin
    osc_wave = pbosc_pkg::WAVE_SINE; osc_step = 32'd42852281; osc_vol = 16'd32768;
    osc_pw = 32'h8000_0000; osc_lfo = 1'b0; osc_sync = 1'b1; osc_start = '0;
    osc_hold_period = 16'd1; osc_phase = '0; osc_active = 1'b0;
    osc_na = 32'h6745_2301; osc_nc = 32'hEFCD_AB89; osc_hold_count = 0; osc_held = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_each_waveform();
    test_corner_settings();
    test_random_phases();
    test_output_stall();
    if (mismatches == 0 && pending_samples.size() == 0) begin
      $display("tb_polyblep_multiwave_oscillator_unit: PASS");
    end else begin
      $display("tb_polyblep_multiwave_oscillator_unit: FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
design/pbosc_pkg.sv
design/pbosc_ctrl.sv
design/pbosc_dp.sv
design/polyblep_multiwave_oscillator_unit.sv
sim/tb_polyblep_multiwave_oscillator_unit.sv
